// ===== hdl/sit_pkg.sv =====
`default_nettype none
package sit_pkg;

    // table geometry
    localparam int CAPACITY    = 64;
    localparam int HANDLE_BITS = 16;
    localparam int POS_BITS    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_BITS    = $clog2(CAPACITY + 1);

    // stream field widths
    localparam int OP_BITS      = 2;
    localparam int ID_BITS      = 31;
    localparam int IN_HDL_BITS  = 16;
    localparam int STATUS_BITS  = 2;
    localparam int OUT_POS_BITS = 6;
    localparam int OUT_HDL_BITS = 16;
    localparam int S_TDATA_BITS = 48;
    localparam int M_TDATA_BITS = 24;
    localparam int M_PAD_BITS   = M_TDATA_BITS - OUT_HDL_BITS - OUT_POS_BITS;

    // operation codes
    localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_BITS-1:0] OP_DELETE = 2'd2;

    // result status codes
    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture a new request
        logic compare;  // run the per-cell compares
        logic execute;  // update the table and load the result register
    } cmd_t;

endpackage
`default_nettype wire

// ===== hdl/sit_datapath.sv =====
`default_nettype none
module sit_datapath
    import sit_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire cmd_t                    cmd,
    input  wire logic [OP_BITS-1:0]      s_op,
    input  wire logic [ID_BITS-1:0]      s_id,
    input  wire logic [IN_HDL_BITS-1:0]  s_hdl,
    output logic [STATUS_BITS-1:0]       res_status,
    output logic [OUT_POS_BITS-1:0]      res_position,
    output logic [OUT_HDL_BITS-1:0]      res_handle
);

    // row of cells
    logic [ID_BITS-1:0]     id_reg  [CAPACITY];
    logic [HANDLE_BITS-1:0] hdl_reg [CAPACITY];
    logic [ID_BITS-1:0]     id_next [CAPACITY];
    logic [HANDLE_BITS-1:0] hdl_next[CAPACITY];
    logic [CNT_BITS-1:0]    count_reg, count_next;

    // captured request
    logic [OP_BITS-1:0]     op_reg;
    logic [ID_BITS-1:0]     key_reg;
    logic [HANDLE_BITS-1:0] new_hdl_reg;

    // compare flags, registered between the two steps
    logic [CAPACITY-1:0] lt_reg, lt_next;
    logic [CAPACITY-1:0] eq_reg, eq_next;

    // result register
    logic [STATUS_BITS-1:0]  status_reg, status_next;
    logic [OUT_POS_BITS-1:0] pos_reg, pos_next;
    logic [OUT_HDL_BITS-1:0] ohdl_reg, ohdl_next;

    logic [CAPACITY-1:0]    boundary;
    logic [POS_BITS-1:0]    pos;
    logic [HANDLE_BITS-1:0] sel_hdl;
    logic                   found;
    logic                   full;
    logic                   ins_ok;
    logic                   del_ok;

    // per-cell compare against the key; cells at or above the count never match
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            lt_next[i] = (CNT_BITS'(i) < count_reg) && (id_reg[i] < key_reg);
            eq_next[i] = (CNT_BITS'(i) < count_reg) && (id_reg[i] == key_reg);
        end
    end

    // lt is a thermometer; its edge is the lower bound
    always_comb begin
        pos     = '0;
        sel_hdl = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            boundary[i] = !lt_reg[i] && ((i == 0) || lt_reg[(i == 0) ? 0 : i - 1]);
            if (boundary[i]) begin
                pos = pos | POS_BITS'(i);
            end
            if (boundary[i] && eq_reg[i]) begin
                sel_hdl = sel_hdl | hdl_reg[i];
            end
        end
    end

    assign found  = |eq_reg;
    assign full   = (count_reg == CNT_BITS'(CAPACITY));
    assign ins_ok = (op_reg == OP_INSERT) && !full;
    assign del_ok = (op_reg == OP_DELETE) && found;

    // cell moves: insert shifts up from the bound, delete pulls down onto it
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            id_next[i]  = id_reg[i];
            hdl_next[i] = hdl_reg[i];
            if (ins_ok) begin
                if (boundary[i]) begin
                    id_next[i]  = key_reg;
                    hdl_next[i] = new_hdl_reg;
                end else if ((i > 0) && !lt_reg[(i == 0) ? 0 : i - 1]) begin
                    id_next[i]  = id_reg[(i == 0) ? 0 : i - 1];
                    hdl_next[i] = hdl_reg[(i == 0) ? 0 : i - 1];
                end
            end else if (del_ok) begin
                if (!lt_reg[i] && (i < CAPACITY - 1)) begin
                    id_next[i]  = id_reg[(i < CAPACITY - 1) ? i + 1 : i];
                    hdl_next[i] = hdl_reg[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_comb begin
        count_next  = count_reg;
        status_next = ST_NOT_FOUND;
        pos_next    = '0;
        ohdl_next   = '0;
        case (op_reg)
            OP_INSERT: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    status_next = ST_OK;
                    pos_next    = OUT_POS_BITS'(pos);
                    count_next  = count_reg + CNT_BITS'(1);
                end
            end
            OP_LOOKUP, OP_DELETE: begin
                if (found) begin
                    status_next = ST_OK;
                    pos_next    = OUT_POS_BITS'(pos);
                    ohdl_next   = OUT_HDL_BITS'(sel_hdl);
                    if (op_reg == OP_DELETE) begin
                        count_next = count_reg - CNT_BITS'(1);
                    end
                end
            end
            default: begin
                status_next = ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.execute) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= s_op;
            key_reg     <= s_id;
            new_hdl_reg <= HANDLE_BITS'(s_hdl);
        end
        if (cmd.compare) begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
        if (cmd.execute) begin
            for (int i = 0; i < CAPACITY; i++) begin
                id_reg[i]  <= id_next[i];
                hdl_reg[i] <= hdl_next[i];
            end
            status_reg <= status_next;
            pos_reg    <= pos_next;
            ohdl_reg   <= ohdl_next;
        end
    end

    assign res_status   = status_reg;
    assign res_position = pos_reg;
    assign res_handle   = ohdl_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute && ins_ok |=> count_reg == $past(count_reg) + CNT_BITS'(1))
        else $error("insert did not add an entry");

    a_full_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute && (op_reg == OP_INSERT) && full |=> count_reg == CNT_BITS'(CAPACITY))
        else $error("insert into full table changed the count");

endmodule
`default_nettype wire

// ===== hdl/sit_ctrl.sv =====
`default_nettype none
module sit_ctrl
    import sit_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_COMPARE = 3'b010,
        ST_EXECUTE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;
    logic   load;
    logic   execute;

    assign out_free = !m_valid_reg || m_tready;
    assign execute  = (state_reg == ST_EXECUTE) && out_free;
    assign s_tready = (state_reg == ST_IDLE) || execute;
    assign load     = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (load) begin
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                state_next = ST_EXECUTE;
            end
            ST_EXECUTE: begin
                if (out_free) begin
                    state_next = load ? ST_COMPARE : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (execute) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid    = m_valid_reg;
    assign cmd.load    = load;
    assign cmd.compare = (state_reg == ST_COMPARE);
    assign cmd.execute = execute;

    a_exec_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute |-> (!m_valid_reg || m_tready))
        else $error("result overwritten before transfer");

    a_exec_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute |=> m_valid_reg)
        else $error("result not presented after execute");

    a_load_compare: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> cmd.compare)
        else $error("accepted request skipped compare");

endmodule
`default_nettype wire

// ===== hdl/sorted_id_table_unit.sv =====
`default_nettype none
// Sorted id table: holds up to 64 entries (31-bit id plus 16-bit handle) in
// ascending id order. Each request on the s_ stream (insert, lookup or delete,
// selected by s_tuser) gives exactly one result on the m_ stream. Insert places
// the new entry ahead of any equal ids and reports its position, or reports
// table full and changes nothing. Lookup and delete act on the lowest-positioned
// matching id and return its position and handle; a missing id or the unused
// op code reports not found. The table is empty after reset; no clearing pass.
// Timing: a request runs in two steps, one where every cell compares its id
// with the key in parallel and one where the cells shift and the result
// register loads. A new request is taken in the same cycle the previous one
// finishes while the result side keeps up; a stalled result holds the execute step.
module sorted_id_table_unit
    import sit_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // request stream
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [S_TDATA_BITS-1:0] s_tdata,   // entry_id[30:0], entry_handle[46:31], pad
    input  wire logic [OP_BITS-1:0]      s_tuser,   // op[1:0]
    // result stream
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [M_TDATA_BITS-1:0]      m_tdata,   // position[5:0], found_handle[21:6], pad
    output logic [STATUS_BITS-1:0]       m_tuser    // status[1:0]
);

    cmd_t                     cmd;
    logic [STATUS_BITS-1:0]   res_status;
    logic [OUT_POS_BITS-1:0]  res_position;
    logic [OUT_HDL_BITS-1:0]  res_handle;

    // sequencing and output valid
    sit_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // cell row, count and result register
    sit_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_op         (s_tuser),
        .s_id         (s_tdata[ID_BITS-1:0]),
        .s_hdl        (s_tdata[ID_BITS +: IN_HDL_BITS]),
        .res_status   (res_status),
        .res_position (res_position),
        .res_handle   (res_handle)
    );

    // pack result fields, lowest first
    assign m_tdata = {{M_PAD_BITS{1'b0}}, res_handle, res_position};
    assign m_tuser = res_status;

endmodule
`default_nettype wire

// ===== sim/sorted_id_table_unit_tb.sv =====
`timescale 1ns / 100ps

// Request/result stream bench for the sorted id table.
// The driver and the ready generator change inputs on the falling edge. The monitor samples
// on the rising edge and checks every result against a table model, in transfer order.
module sorted_id_table_unit_tb;
    import sit_pkg::*;

    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;   // reserved code, must act as a miss
    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 6;
    localparam int HOLD_CYCLES  = 120;                 // long result-side stall
    localparam int POOL_SIZE    = 24;
    localparam int PRINT_LIMIT  = 60;

    typedef struct {
        logic [OP_BITS-1:0]     op;
        logic [ID_BITS-1:0]     id;
        logic [IN_HDL_BITS-1:0] handle;
    } request_t;

    typedef struct {
        logic [STATUS_BITS-1:0]  status;
        logic [OUT_POS_BITS-1:0] position;
        logic [OUT_HDL_BITS-1:0] handle;
    } result_t;

    // ---------------------------------------------------------------------
    // Clock, reset and DUT
    // ---------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata  = '0;
    logic [OP_BITS-1:0]      s_tuser  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic [STATUS_BITS-1:0]  m_tuser;

    always #(HALF_PERIOD) aclk = ~aclk;

    sorted_id_table_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // entry_id[30:0], entry_handle[46:31], pad
        .s_tuser  (s_tuser),    // op[1:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // position[5:0], found_handle[21:6], pad
        .m_tuser  (m_tuser)     // status[1:0]
    );

    // ---------------------------------------------------------------------
    // Bench state
    // ---------------------------------------------------------------------
    request_t pending_q[$];         // requests not yet offered
    result_t  expected_q[$];        // predicted results, oldest first

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;          // bumped by the sequencer to ask for a long stall
    int hold_ack      = 0;
    int hold_left     = 0;
    logic req_taken   = 1'b0;       // request transfer seen at the last rising edge

    int error_count   = 0;
    int op_count[4]   = '{0, 0, 0, 0};
    int full_count    = 0;
    int miss_count    = 0;
    int result_count  = 0;
    int peak_entries  = 0;

    logic [ID_BITS-1:0] id_pool[POOL_SIZE];

    // table model: ascending ids in slots 0 .. tbl_count-1
    logic [ID_BITS-1:0]     tbl_id  [CAPACITY];
    logic [HANDLE_BITS-1:0] tbl_hdl [CAPACITY];
    int                     tbl_count = 0;

    // ---------------------------------------------------------------------
    // Table model: apply one request, return the result it must produce
    // ---------------------------------------------------------------------
    function automatic result_t table_apply(request_t rq);
        result_t r;
        int      slot;
        bit      hit;
        r.status   = ST_NOT_FOUND;
        r.position = '0;
        r.handle   = '0;
        // first slot whose id is not below the key
        slot = 0;
        while (slot < tbl_count && tbl_id[slot] < rq.id)
            slot++;
        hit = (slot < tbl_count) && (tbl_id[slot] == rq.id);
        case (rq.op)
            OP_INSERT: begin
                if (tbl_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    // new entry lands below any equal ids
                    for (int i = tbl_count; i > slot; i--) begin
                        tbl_id[i]  = tbl_id[i-1];
                        tbl_hdl[i] = tbl_hdl[i-1];
                    end
                    tbl_id[slot]  = rq.id;
                    tbl_hdl[slot] = rq.handle;
                    tbl_count++;
                    r.status   = ST_OK;
                    r.position = OUT_POS_BITS'(slot);
                end
            end
            OP_LOOKUP: begin
                if (hit) begin
                    r.status   = ST_OK;
                    r.position = OUT_POS_BITS'(slot);
                    r.handle   = OUT_HDL_BITS'(tbl_hdl[slot]);
                end
            end
            OP_DELETE: begin
                if (hit) begin
                    r.status   = ST_OK;
                    r.position = OUT_POS_BITS'(slot);
                    r.handle   = OUT_HDL_BITS'(tbl_hdl[slot]);
                    for (int i = slot; i + 1 < tbl_count; i++) begin
                        tbl_id[i]  = tbl_id[i+1];
                        tbl_hdl[i] = tbl_hdl[i+1];
                    end
                    tbl_count--;
                end
            end
            default: ;   // reserved op: miss, table untouched
        endcase
        if (tbl_count > peak_entries)
            peak_entries = tbl_count;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // ---------------------------------------------------------------------
    // Driver: offers pending requests, holds each until its transfer
    // ---------------------------------------------------------------------
    always @(negedge aclk) begin
        request_t rq;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_taken) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                rq = pending_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {{(S_TDATA_BITS - ID_BITS - IN_HDL_BITS){1'b0}}, rq.handle, rq.id};
                s_tuser  <= rq.op;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result-side ready: random backpressure, or a long hold-off on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: predicts on request transfers, checks result transfers
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        request_t rq;
        result_t  want;
        req_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                result_count++;
                if (expected_q.size() == 0) begin
                    report_mismatch("result with nothing outstanding", 32'(m_tdata), 32'd0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", 32'(m_tuser), 32'(want.status));
                    if (m_tdata[OUT_POS_BITS-1:0] !== want.position)
                        report_mismatch("position", 32'(m_tdata[OUT_POS_BITS-1:0]),
                                        32'(want.position));
                    if (m_tdata[OUT_POS_BITS +: OUT_HDL_BITS] !== want.handle)
                        report_mismatch("found_handle",
                                        32'(m_tdata[OUT_POS_BITS +: OUT_HDL_BITS]),
                                        32'(want.handle));
                end
            end
            if (s_tvalid && s_tready) begin
                rq.op     = s_tuser;
                rq.id     = s_tdata[ID_BITS-1:0];
                rq.handle = s_tdata[ID_BITS +: IN_HDL_BITS];
                want = table_apply(rq);
                op_count[rq.op]++;
                if (want.status == ST_FULL)
                    full_count++;
                if (want.status == ST_NOT_FOUND)
                    miss_count++;
                expected_q.push_back(want);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    task automatic queue_req(logic [OP_BITS-1:0] op, logic [ID_BITS-1:0] id,
                             logic [IN_HDL_BITS-1:0] handle);
        request_t rq;
        rq.op     = op;
        rq.id     = id;
        rq.handle = handle;
        pending_q.push_back(rq);
    endtask

    // Mostly pool ids so lookups/deletes hit and duplicates pile up; some fully random ids.
    task automatic queue_random(int n, int ins_pct, int del_pct);
        int                 pick;
        logic [ID_BITS-1:0] id;
        logic [OP_BITS-1:0] op;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < ins_pct)
                op = OP_INSERT;
            else if (pick < ins_pct + del_pct)
                op = OP_DELETE;
            else if (pick < 97)
                op = OP_LOOKUP;
            else
                op = OP_UNUSED;
            if ($urandom_range(0, 3) != 0)
                id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                id = ID_BITS'($urandom);
            queue_req(op, id, IN_HDL_BITS'($urandom));
        end
    endtask

    // Sender pause: nothing left to offer and every result back
    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_q.size() != 0 || s_tvalid || expected_q.size() != 0);
    endtask

    initial begin
        id_pool[0] = '0;
        id_pool[1] = 31'd1;
        id_pool[2] = 31'h2AAA_AAAA;
        id_pool[3] = 31'h5555_5555;
        id_pool[4] = 31'h7FFF_FFFE;
        id_pool[5] = 31'h7FFF_FFFF;
        for (int k = 6; k < POOL_SIZE; k++)
            id_pool[k] = ID_BITS'($urandom);

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // sender idles lightly, receiver heavily
        send_idle_pct = 24;
        recv_idle_pct = 65;

        // directed: empty table, extremes, duplicates, reserved op
        queue_req(OP_LOOKUP, 31'd5, 16'h0000);            // miss on empty
        queue_req(OP_DELETE, 31'd5, 16'h0000);            // miss on empty
        queue_req(OP_UNUSED, 31'd0, 16'h0000);
        queue_req(OP_INSERT, 31'h7FFF_FFFF, 16'hFFFF);
        queue_req(OP_INSERT, 31'h0000_0000, 16'h0000);
        queue_req(OP_INSERT, 31'h2AAA_AAAA, 16'h5555);
        queue_req(OP_INSERT, 31'h5555_5555, 16'hAAAA);
        queue_req(OP_INSERT, 31'h2AAA_AAAA, 16'h1234);    // goes below the equal id
        queue_req(OP_LOOKUP, 31'h2AAA_AAAA, 16'h0000);    // lowest of the duplicates
        queue_req(OP_LOOKUP, 31'h7FFF_FFFF, 16'h0000);
        queue_req(OP_LOOKUP, 31'h0000_0000, 16'h0000);
        queue_req(OP_LOOKUP, 31'h2AAA_AAAB, 16'h0000);    // near miss
        queue_req(OP_UNUSED, 31'h2AAA_AAAA, 16'h0001);    // must not touch the table
        queue_req(OP_DELETE, 31'h2AAA_AAAA, 16'h0000);    // removes the lower duplicate
        queue_req(OP_LOOKUP, 31'h2AAA_AAAA, 16'h0000);
        queue_req(OP_INSERT, 31'h0000_0001, 16'h8001);
        queue_req(OP_DELETE, 31'h7FFF_FFFE, 16'h0000);    // miss just below the top id
        queue_req(OP_DELETE, 31'h7FFF_FFFF, 16'hFFFF);
        queue_req(OP_DELETE, 31'h0000_0000, 16'h0000);
        queue_req(OP_LOOKUP, 31'h0000_0001, 16'hFFFF);    // handle field ignored
        queue_req(OP_DELETE, 31'h5555_5555, 16'hFFFF);
        queue_req(OP_UNUSED, 31'h7FFF_FFFF, 16'hFFFF);
        wait_drained();

        queue_random(60, 50, 23);
        wait_drained();

        // long result stall while the sender keeps pushing: input must back up
        send_idle_pct = 0;
        hold_req++;
        queue_random(20, 50, 23);
        do @(posedge aclk);
        while (hold_ack != hold_req || hold_left != 0);
        send_idle_pct = 24;
        queue_random(60, 50, 23);
        wait_drained();

        // roles swapped: sender idles heavily, receiver lightly
        send_idle_pct = 65;
        recv_idle_pct = 24;
        queue_random(70, 100, 0);       // fill past capacity, table-full results
        queue_random(80, 60, 20);       // hover near full
        wait_drained();
        queue_random(60, 15, 60);       // drain-heavy
        wait_drained();

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(80, 45, 23);
        wait_drained();

        repeat (20) @(posedge aclk);
        $display("summary: %0d requests (ins %0d, look %0d, del %0d, rsvd %0d), %0d results",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[0], op_count[1], op_count[2], op_count[3], result_count);
        $display("summary: %0d table-full, %0d not-found, peak occupancy %0d of %0d",
                 full_count, miss_count, peak_entries, CAPACITY);
        if (error_count == 0)
            $display("sorted_id_table_unit_tb: clean");
        else
            $display("sorted_id_table_unit_tb: errors");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", expected_q.size());
        $display("sorted_id_table_unit_tb: errors");
        $finish;
    end

endmodule
